// ----- design/sobel_edge_magnitude_unit_assert.svh -----
// Assertion macros, clocked on clock, disabled during reset.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SEM_ASSERT_IMPL(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define SEM_ASSERT_NEXT(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) else $error(msg);

`endif

// ----- design/sem_pkg.sv -----
`default_nettype none
package sem_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int DIM_W   = 12;                    // config register width
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int POS_W   = COL_W + ROW_W;
   localparam int TOTAL_W = POS_W + 1;
   localparam int PIX_W   = 8;
   localparam int MAG_W   = 11;
   localparam int GRAD_W  = PIX_W + 2;             // |gx|, |gy| <= 1020
   localparam int RAD_W   = 2 * MAG_W;             // radicand, padded to even
   localparam int REM_W   = MAG_W + 1;
   localparam int ROOT_STEPS = MAG_W;
   localparam int CNT_W   = $clog2(ROOT_STEPS);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;     // latch pixel, issue row store reads
      logic step;        // shift window, write row stores, advance counters
      logic grad;        // form |gx|, |gy|
      logic square;      // sum of squares, start root
      logic root_step;   // one root digit
      logic clear_mag;   // result is zero
      logic emit;        // load output register, advance position
   } cmd_type;

   typedef struct packed {
      logic draining;
      logic due;
      logic interior;
      logic root_last;
   } status_type;

endpackage
`default_nettype wire

// ----- design/sobel_edge_magnitude_unit.sv -----
// Channel   | Ports                                  | Direction
// req       | req_valid/ready, req_kind, req_pixel   | in, one pixel or drain per transfer
// rsp       | rsp_valid/ready, rsp_magnitude, _end   | out, zero or one result per input
// csr       | csr_we, csr_index, csr_wdata           | in, write only, no wait
//
// Pixel with a result: read, gradient, square, 11 root digits, load; a border result
// skips square and root. A pixel without a result returns to idle after the gradient.
// While draining, any transfer loads a zero result directly. One item in flight.
// Synchronous active-high reset; row stores and window are not cleared, since every
// tap of a nonzero result is rewritten in the current frame.
// A stalled result holds in the output register; the next result waits to load.
`default_nettype none
module sobel_edge_magnitude_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic [sem_pkg::PIX_W-1:0] req_pixel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [sem_pkg::MAG_W-1:0] rsp_magnitude,
   output logic                           rsp_frame_end,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [sem_pkg::DIM_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   sem_pkg::cmd_type    cmd;
   sem_pkg::status_type status;

   // sequencer: one state per datapath step, output register valid
   sem_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: row stores, 3x3 window, gradients, root unit, counters
   sem_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_pixel     (req_pixel),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_magnitude (rsp_magnitude),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

// ----- design/sem_ram.sv -----
`default_nettype none
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/sem_datapath.sv -----
`default_nettype none
module sem_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sem_pkg::cmd_type          cmd,
   output sem_pkg::status_type            status,
   input  wire logic [sem_pkg::PIX_W-1:0] req_pixel,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [sem_pkg::DIM_W-1:0] csr_wdata,
   output logic      [sem_pkg::MAG_W-1:0] rsp_magnitude,
   output logic                           rsp_frame_end
);

   localparam logic [sem_pkg::DIM_W-1:0] MAX_W_DIM = sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH);
   localparam logic [sem_pkg::DIM_W-1:0] MAX_H_DIM = sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT);

   logic [sem_pkg::DIM_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [sem_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [sem_pkg::COL_W-1:0]   col_ff, col_in;
   logic [sem_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [sem_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        draining_ff, draining_in;
   logic [sem_pkg::PIX_W-1:0]   px_ff;
   logic [sem_pkg::PIX_W-1:0]   win_ff [9];
   logic                        due_ff, interior_ff;
   logic [sem_pkg::GRAD_W-1:0]  gxa_ff, gya_ff;
   logic [sem_pkg::RAD_W-1:0]   rad_ff;
   logic [sem_pkg::REM_W-1:0]   rem_ff;
   logic [sem_pkg::MAG_W-1:0]   root_ff, mag_ff;
   logic [sem_pkg::CNT_W-1:0]   cnt_ff;

   logic [sem_pkg::DIM_W-1:0]   w_eff, h_eff;
   logic [sem_pkg::PIX_W-1:0]   up_rd, mid_rd;
   logic [sem_pkg::TOTAL_W-1:0] pos_next;
   logic [sem_pkg::GRAD_W-1:0]  gx_p, gx_n, gy_p, gy_n;
   logic [sem_pkg::REM_W+1:0]   trial_rem, trial_sub, trial_diff;
   logic                        trial_ge;
   logic [sem_pkg::MAG_W-1:0]   root_next;

   // effective dimensions, zero acts as one, over-range saturates to the maximum
   always_comb begin
      priority if (width_ff == '0)       w_eff = sem_pkg::DIM_W'(1);
      else if (width_ff > MAX_W_DIM)     w_eff = MAX_W_DIM;
      else                               w_eff = width_ff;
      priority if (height_ff == '0)      h_eff = sem_pkg::DIM_W'(1);
      else if (height_ff > MAX_H_DIM)    h_eff = MAX_H_DIM;
      else                               h_eff = height_ff;
   end

   sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (col_ff),
      .wr_data (mid_rd),
      .rd_en   (cmd.capture),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (col_ff),
      .wr_data (px_ff),
      .rd_en   (cmd.capture),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   assign pos_next = {1'b0, pos_ff} + sem_pkg::TOTAL_W'(1);

   // counters, frame restart on any register write
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pos_in      = pos_ff;
      draining_in = draining_ff;
      total_in    = sem_pkg::TOTAL_W'(w_eff * h_eff);
      if (csr_we) begin
         unique case (csr_index)
            sem_pkg::REG_FRAME_WIDTH:  width_in  = csr_wdata;
            sem_pkg::REG_FRAME_HEIGHT: height_in = csr_wdata;
            default:                   width_in  = width_ff;
         endcase
         col_in      = '0;
         row_in      = '0;
         pos_in      = '0;
         draining_in = 1'b0;
      end else begin
         if (cmd.step) begin
            if (({1'b0, col_ff} + sem_pkg::DIM_W'(1)) == w_eff) begin
               col_in = '0;
               if (({1'b0, row_ff} + sem_pkg::DIM_W'(1)) == h_eff) begin
                  row_in      = '0;
                  draining_in = 1'b1;
               end else begin
                  row_in = row_ff + sem_pkg::ROW_W'(1);
               end
            end else begin
               col_in = col_ff + sem_pkg::COL_W'(1);
            end
         end
         if (cmd.emit) begin
            if (pos_next >= total_ff) begin
               pos_in      = '0;
               draining_in = 1'b0;
            end else begin
               pos_in = pos_next[sem_pkg::POS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= sem_pkg::WIDTH_RESET;
         height_ff   <= sem_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         pos_ff      <= '0;
         draining_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pos_ff      <= pos_in;
         draining_ff <= draining_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // window sums, kept unsigned
   assign gx_p = sem_pkg::GRAD_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0}
                 + sem_pkg::GRAD_W'(win_ff[8]);
   assign gx_n = sem_pkg::GRAD_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0}
                 + sem_pkg::GRAD_W'(win_ff[6]);
   assign gy_p = sem_pkg::GRAD_W'(win_ff[6]) + {1'b0, win_ff[7], 1'b0}
                 + sem_pkg::GRAD_W'(win_ff[8]);
   assign gy_n = sem_pkg::GRAD_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0}
                 + sem_pkg::GRAD_W'(win_ff[2]);

   // one root digit per step
   assign trial_rem  = {rem_ff, rad_ff[sem_pkg::RAD_W-1 -: 2]};
   assign trial_sub  = {1'b0, root_ff, 2'b01};
   assign trial_ge   = trial_rem >= trial_sub;
   assign trial_diff = trial_rem - trial_sub;
   assign root_next  = {root_ff[sem_pkg::MAG_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= req_pixel;
      end
      if (cmd.step) begin
         win_ff[0]   <= win_ff[1];
         win_ff[1]   <= win_ff[2];
         win_ff[2]   <= up_rd;
         win_ff[3]   <= win_ff[4];
         win_ff[4]   <= win_ff[5];
         win_ff[5]   <= mid_rd;
         win_ff[6]   <= win_ff[7];
         win_ff[7]   <= win_ff[8];
         win_ff[8]   <= px_ff;
         due_ff      <= (row_ff >= sem_pkg::ROW_W'(2))
                        || ((row_ff == sem_pkg::ROW_W'(1)) && (col_ff != '0));
         interior_ff <= (row_ff >= sem_pkg::ROW_W'(2)) && (col_ff >= sem_pkg::COL_W'(2));
      end
      if (cmd.grad) begin
         gxa_ff <= (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
         gya_ff <= (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
      end
      if (cmd.square) begin
         rad_ff  <= sem_pkg::RAD_W'(gxa_ff * gxa_ff) + sem_pkg::RAD_W'(gya_ff * gya_ff);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= {rad_ff[sem_pkg::RAD_W-3:0], 2'b00};
         rem_ff  <= trial_ge ? trial_diff[sem_pkg::REM_W-1:0]
                             : trial_rem[sem_pkg::REM_W-1:0];
         root_ff <= root_next;
         cnt_ff  <= cnt_ff + sem_pkg::CNT_W'(1);
         if (status.root_last) begin
            mag_ff <= root_next;
         end
      end
      if (cmd.clear_mag) begin
         mag_ff <= '0;
      end
      if (cmd.emit) begin
         rsp_magnitude <= mag_ff;
         rsp_frame_end <= pos_next == total_ff;
      end
   end

   always_comb begin
      status.draining  = draining_ff;
      status.due       = due_ff;
      status.interior  = interior_ff;
      status.root_last = cnt_ff == sem_pkg::CNT_W'(sem_pkg::ROOT_STEPS - 1);
   end

endmodule
`default_nettype wire

// ----- design/sem_control.sv -----
`default_nettype none
module sem_control (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_kind,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sem_pkg::cmd_type         cmd,
   input  wire sem_pkg::status_type status
);

   sem_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, out_free;

   assign req_ready = state_ff == sem_pkg::ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sem_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (status.draining)          state_in = sem_pkg::ST_EMIT;
               else if (req_kind == sem_pkg::KIND_PIXEL) state_in = sem_pkg::ST_READ;
               else                                   state_in = sem_pkg::ST_IDLE;
            end
         end
         sem_pkg::ST_READ: state_in = sem_pkg::ST_GRAD;
         sem_pkg::ST_GRAD: begin
            priority if (!status.due)     state_in = sem_pkg::ST_IDLE;
            else if (!status.interior)    state_in = sem_pkg::ST_EMIT;
            else                          state_in = sem_pkg::ST_SQUARE;
         end
         sem_pkg::ST_SQUARE: state_in = sem_pkg::ST_ROOT;
         sem_pkg::ST_ROOT: begin
            if (status.root_last) state_in = sem_pkg::ST_EMIT;
         end
         sem_pkg::ST_EMIT: begin
            if (out_free) state_in = sem_pkg::ST_IDLE;
         end
         default: state_in = sem_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         sem_pkg::ST_IDLE: begin
            cmd.capture   = accept && !status.draining
                            && (req_kind == sem_pkg::KIND_PIXEL);
            cmd.clear_mag = accept && status.draining;
         end
         sem_pkg::ST_READ:   cmd.step      = 1'b1;
         sem_pkg::ST_GRAD: begin
            cmd.grad      = 1'b1;
            cmd.clear_mag = !status.interior;
         end
         sem_pkg::ST_SQUARE: cmd.square    = 1'b1;
         sem_pkg::ST_ROOT:   cmd.root_step = 1'b1;
         sem_pkg::ST_EMIT:   cmd.emit      = out_free;
         default:            cmd           = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sem_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`include "sobel_edge_magnitude_unit_assert.svh"

   `SEM_ASSERT_NEXT(a_pixel_reads, accept && !status.draining && req_kind == sem_pkg::KIND_PIXEL, state_ff == sem_pkg::ST_READ, "pixel transfer did not start a row store read")
   `SEM_ASSERT_NEXT(a_emit_loads, cmd.emit, rsp_valid_ff, "emit did not present a result")
   `SEM_ASSERT_IMPL(a_no_overwrite, cmd.emit, !rsp_valid_ff || rsp_ready, "result overwritten before transfer")
   `SEM_ASSERT_IMPL(a_border_zero, state_ff == sem_pkg::ST_GRAD && !status.interior, cmd.clear_mag, "border position not cleared")

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
// Sobel edge magnitude unit: self-checking bench.
// A queue of pending operations (pixel or drain transfers, CSR writes, settle points)
// feeds a driver that works on the falling edge. A monitor on the rising edge runs a
// behavioral model of the line stores, window and root on every accepted req transfer
// and checks each rsp transfer against the oldest predicted result.
module tb_top;
   import sem_pkg::*;

   localparam int SETTLE_CYCLES  = 24;     // quiet time required before a CSR write or settle point
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transfer
   localparam int RANDOM_ITEMS   = 360;

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_SETTLE} op_kind_type;

   typedef struct {
      op_kind_type           op;
      logic                  kind;
      logic [PIX_W-1:0]      pixel;
      logic                  index;
      logic [DIM_W-1:0]      data;
   } pending_op_type;

   typedef struct {
      logic [MAG_W-1:0] magnitude;
      logic             frame_end;
   } edge_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_kind = KIND_PIXEL;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [MAG_W-1:0] rsp_magnitude;
   logic             rsp_frame_end;
   logic             csr_we = 1'b0;
   logic             csr_index = REG_FRAME_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   pending_op_type  pending_ops[$];
   edge_result_type expected_edges[$];

   // Behavioral image of the unit
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [7:0]       upper_line[MAX_WIDTH];
   logic [7:0]       middle_line[MAX_WIDTH];
   logic [7:0]       window[9];
   int unsigned      in_col;
   int unsigned      in_row;
   int unsigned      out_pos;
   bit               draining;

   bit          req_taken = 0;       // req transfer at the last rising edge
   int unsigned quiet_cycles = 0;    // cycles since the last transfer
   int unsigned watchdog = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   sobel_edge_magnitude_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_magnitude(rsp_magnitude), .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned floor_root(int unsigned s);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= s) r++;
      return r;
   endfunction

   task automatic restart_frame();
      in_col = 0;
      in_row = 0;
      out_pos = 0;
      draining = 0;
   endtask

   // Advance the model by one accepted transfer; queue any result it yields.
   task automatic sobel_predict(logic kind, logic [7:0] px);
      int unsigned     w, h, total, col, row, n, mag;
      int              gx, gy;
      edge_result_type r;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      total = w * h;
      if (draining) begin
         // trailing border output; a pixel here is thrown away
         r.magnitude = '0;
         r.frame_end = (out_pos + 1 == total);
         expected_edges = {expected_edges, r};
         out_pos++;
         if (out_pos >= total) begin
            out_pos = 0;
            draining = 0;
         end
         return;
      end
      if (kind == KIND_DRAIN) return;   // nothing pending: ignored
      col = (in_col >= w) ? w - 1 : in_col;
      row = (in_row >= h) ? h - 1 : in_row;
      n = row * w + col;
      for (int k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = upper_line[col];
      window[5] = middle_line[col];
      window[8] = px;
      upper_line[col] = middle_line[col];
      middle_line[col] = px;
      if (n >= w + 1) begin
         mag = 0;
         if (row >= 2 && col >= 2) begin
            gx = window[2] + 2 * window[5] + window[8]
               - window[0] - 2 * window[3] - window[6];
            gy = window[6] + 2 * window[7] + window[8]
               - window[0] - 2 * window[1] - window[2];
            mag = floor_root(gx * gx + gy * gy);
         end
         r.magnitude = mag[MAG_W-1:0];
         r.frame_end = (out_pos + 1 == total);
         expected_edges = {expected_edges, r};
         out_pos++;
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) begin
            row = 0;
            draining = 1;
         end
      end
      in_col = col;
      in_row = row;
   endtask

   // Monitor: CSR writes, req transfers, rsp checks, watchdog.
   always @(posedge clock) begin
      req_taken = 0;
      if (reset) begin
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (upper_line[i]) upper_line[i] = '0;
         foreach (middle_line[i]) middle_line[i] = '0;
         foreach (window[i]) window[i] = '0;
         restart_frame();
      end else begin
         cycle_count++;
         quiet_cycles++;
         watchdog++;
         if (csr_we) begin
            if (csr_index == REG_FRAME_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
            restart_frame();
         end
         // check before predicting so a stray result cannot match a fresh entry
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            watchdog = 0;
            if (expected_edges.size() == 0) begin
               $error("unexpected rsp transfer: magnitude %0d frame_end %0d",
                      rsp_magnitude, rsp_frame_end);
               error_count++;
            end else begin
               edge_result_type e;
               e = expected_edges.pop_front();
               if (rsp_magnitude !== e.magnitude) begin
                  $error("magnitude: expected %0d, got %0d", e.magnitude, rsp_magnitude);
                  error_count++;
               end
               if (rsp_frame_end !== e.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", e.frame_end, rsp_frame_end);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1;
            quiet_cycles = 0;
            watchdog = 0;
            sobel_predict(req_kind, req_pixel);
         end
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Driver: one nonblocking update per signal per falling edge.
   always @(negedge clock) begin
      logic             nv, nk, nwe, nidx;
      logic [7:0]       np;
      logic [DIM_W-1:0] nd;
      bit               burst;
      nv = req_valid && !req_taken;   // an unaccepted transfer holds
      nk = req_kind;
      np = req_pixel;
      nwe = 1'b0;
      nidx = csr_index;
      nd = csr_wdata;
      if (!reset) begin
         burst = (items_sent >= 150 && items_sent < 260);
         if (!nv && !csr_we && pending_ops.size() > 0) begin
            case (pending_ops[0].op)
               OP_ITEM: begin
                  if (burst || $urandom_range(0, 99) >= 20) begin
                     nv = 1'b1;
                     nk = pending_ops[0].kind;
                     np = pending_ops[0].pixel;
                     items_sent++;
                     void'(pending_ops.pop_front());
                  end
               end
               OP_CSR: begin
                  if (expected_edges.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                     nwe = 1'b1;
                     nidx = pending_ops[0].index;
                     nd = pending_ops[0].data;
                     void'(pending_ops.pop_front());
                  end
               end
               default: begin
                  if (expected_edges.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                     void'(pending_ops.pop_front());
               end
            endcase
         end
         rsp_ready <= burst || ($urandom_range(0, 99) >= 20);
      end
      req_valid <= nv;
      req_kind  <= nk;
      req_pixel <= np;
      csr_we    <= nwe;
      csr_index <= nidx;
      csr_wdata <= nd;
   end

   task automatic add_item(logic kind, logic [7:0] px);
      pending_op_type o;
      o.op = OP_ITEM;
      o.kind = kind;
      o.pixel = px;
      o.index = REG_FRAME_WIDTH;
      o.data = '0;
      pending_ops = {pending_ops, o};
   endtask

   task automatic add_csr(logic idx, logic [DIM_W-1:0] value);
      pending_op_type o;
      o.op = OP_CSR;
      o.kind = KIND_PIXEL;
      o.pixel = '0;
      o.index = idx;
      o.data = value;
      pending_ops = {pending_ops, o};
   endtask

   task automatic add_settle();
      pending_op_type o;
      o.op = OP_SETTLE;
      o.kind = KIND_PIXEL;
      o.pixel = '0;
      o.index = REG_FRAME_WIDTH;
      o.data = '0;
      pending_ops = {pending_ops, o};
   endtask

   // Half hard 0/255 steps to get large gradients, the other half any level.
   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int unsigned counted, w, h, npix;
      bit          cut;
      logic [7:0]  corner[9];
      // directed: drain with nothing pending, then a few pixels at the reset size
      add_item(KIND_DRAIN, 8'h00);
      add_item(KIND_PIXEL, 8'hFF);
      add_item(KIND_PIXEL, 8'h00);
      add_item(KIND_PIXEL, 8'hA5);
      // 3x3 frame: one interior point with a steep corner
      add_csr(REG_FRAME_WIDTH, 12'd3);
      add_csr(REG_FRAME_HEIGHT, 12'd3);
      corner = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
      foreach (corner[i])
         add_item(KIND_PIXEL, corner[i]);
      add_item(KIND_DRAIN, 8'h00);
      add_item(KIND_PIXEL, 8'h5A);     // pixel while draining acts as a drain
      add_item(KIND_DRAIN, 8'h00);
      add_item(KIND_DRAIN, 8'h00);
      // zero width/height act as one: single-pixel frame
      add_csr(REG_FRAME_WIDTH, 12'd0);
      add_csr(REG_FRAME_HEIGHT, 12'd0);
      add_item(KIND_PIXEL, 8'h81);
      add_item(KIND_DRAIN, 8'h00);
      // over-range sizes saturate; frame cut short by the next write
      add_csr(REG_FRAME_WIDTH, 12'hFFF);
      add_csr(REG_FRAME_HEIGHT, 12'hFFF);
      add_item(KIND_PIXEL, 8'h7E);
      add_item(KIND_PIXEL, 8'h01);
      add_settle();
      // random frames, mostly well formed
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         add_csr(REG_FRAME_WIDTH, DIM_W'(w));
         add_csr(REG_FRAME_HEIGHT, DIM_W'(h));
         cut = ($urandom_range(0, 99) < 8);
         npix = cut ? $urandom_range(0, w * h - 1) : w * h;
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               add_item(KIND_DRAIN, pick_pixel());
               counted++;
            end
            add_item(KIND_PIXEL, pick_pixel());
            counted++;
         end
         if (!cut) begin
            for (int i = 0; i <= w; i++) begin
               if ($urandom_range(0, 4) == 0) add_item(KIND_PIXEL, pick_pixel());
               else add_item(KIND_DRAIN, pick_pixel());
               counted++;
            end
         end
         // hold off now and then until every result is back
         if ($urandom_range(0, 3) == 0) add_settle();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0);
      while (req_valid || expected_edges.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_edges.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
